/* src/bpc_pkg.sv */
// Shared types and constants for the board pin controller.
package bpc_pkg;

   // Item opcodes
   typedef enum logic [3:0] {
      OP_TICK    = 4'd0,
      OP_RELAY   = 4'd1,
      OP_POWER   = 4'd2,
      OP_RESET   = 4'd3,
      OP_PULSE   = 4'd4,
      OP_LOADER  = 4'd5,
      OP_MASKROM = 4'd6,
      OP_BUTTON  = 4'd7,
      OP_POP     = 4'd8
   } opcode_type;

   // Logged event kinds
   typedef enum logic [2:0] {
      EV_RELAY     = 3'd0,
      EV_POWER     = 3'd1,
      EV_RST_ASSRT = 3'd2,
      EV_RST_REL   = 3'd3,
      EV_PULSE_END = 3'd4,
      EV_LOADER    = 3'd5,
      EV_MASKROM   = 3'd6
   } event_kind_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_DEBOUNCE  = 1'b0,
      CSR_MAX_PULSE = 1'b1
   } csr_index_type;

   // Pin positions in the pin vector
   localparam int PIN_RELAY   = 0;
   localparam int PIN_POWER   = 1;
   localparam int PIN_RESET   = 2;
   localparam int PIN_LOADER  = 3;
   localparam int PIN_MASKROM = 4;
   localparam int NUM_PINS    = 5;

   localparam int          RING_DEPTH_DEF    = 8;
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd80;
   localparam logic [15:0] MAX_PULSE_RESET   = 16'd5000;
   localparam logic [15:0] MIN_PULSE_LEN     = 16'd1;

   // One stored event
   typedef struct packed {
      event_kind_type kind;
      logic           origin;
      logic           level;
      logic [15:0]    argument;
      logic [31:0]    stamp;
   } event_type;

endpackage

/* src/board_pin_control_with_reset_pulse_core.sv */
// Board pin controller: five pins, ms counter, timed reset pulse, event ring.
//
// Every item (tick, pin set, pulse start, button edge, pop) is handled in the
// cycle it is accepted and its result lands in the output register on that
// edge, so the block takes one item per cycle whenever the result side keeps
// up; req_ready drops only while an untaken result sits in the output
// register. The event ring is a RING_DEPTH-entry memory holding at most
// RING_DEPTH-1 events; a pop reads it through a registered read port. Events
// that arrive with the ring full are dropped. Ring contents need no clearing
// after reset since only written entries are ever read.
module board_pin_control_with_reset_pulse_core #(
   parameter int RING_DEPTH = bpc_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic        req_level,
   input  logic [15:0] req_pulse_length,
   input  logic        req_origin_id,
   input  logic        req_button_pressed,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_command_ok,
   output logic [4:0]  rsp_pin_states,
   output logic        rsp_pulse_running,
   output logic [15:0] rsp_pulse_left,
   output logic        rsp_event_valid,
   output logic [2:0]  rsp_event_kind,
   output logic        rsp_event_origin,
   output logic        rsp_event_level,
   output logic [15:0] rsp_event_argument,
   output logic [31:0] rsp_event_time
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   // Configuration registers
   logic [15:0] debounce_ff, max_pulse_ff;

   // Control state
   logic [bpc_pkg::NUM_PINS-1:0] pins_ff, pins_in;
   logic [31:0]      ms_ff, ms_in;
   logic             pulse_act_ff, pulse_act_in;
   logic [31:0]      pulse_start_ff, pulse_start_in;
   logic [15:0]      pulse_len_ff, pulse_len_in;
   logic             pulse_org_ff, pulse_org_in;
   logic [31:0]      last_press_ff, last_press_in;
   logic             press_seen_ff, press_seen_in;
   logic [PTR_W-1:0] head_ff, tail_ff, head_in, tail_in;

   // Result register
   logic rsp_valid_ff, ok_ff, ev_valid_ff;
   logic ok_in, ev_valid_in;

   // Event ring
   bpc_pkg::event_type ring_mem [RING_DEPTH];
   bpc_pkg::event_type rd_data_ff;
   bpc_pkg::event_type wr_entry;
   logic               log_req, wr_en, pop_take;

   logic             take;
   logic [PTR_W-1:0] head_nxt, tail_nxt;
   logic             ring_full, ring_empty;
   logic [31:0]      tick_ms, tick_el, press_el, el_now, left_full;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   // Ring pointer arithmetic
   assign head_nxt   = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign tail_nxt   = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
   assign ring_full  = (head_nxt == tail_ff);
   assign ring_empty = (head_ff == tail_ff);

   assign tick_ms  = ms_ff + 32'd1;
   assign tick_el  = tick_ms - pulse_start_ff;
   assign press_el = ms_ff - last_press_ff;

   // Per-item state update
   always_comb begin
      pins_in        = pins_ff;
      ms_in          = ms_ff;
      pulse_act_in   = pulse_act_ff;
      pulse_start_in = pulse_start_ff;
      pulse_len_in   = pulse_len_ff;
      pulse_org_in   = pulse_org_ff;
      last_press_in  = last_press_ff;
      press_seen_in  = press_seen_ff;
      ok_in          = 1'b0;
      ev_valid_in    = 1'b0;
      pop_take       = 1'b0;
      log_req        = 1'b0;
      wr_entry       = '{kind: bpc_pkg::EV_RELAY, origin: req_origin_id,
                         level: req_level, argument: 16'd0, stamp: ms_ff};

      unique case (bpc_pkg::opcode_type'(req_opcode))
         bpc_pkg::OP_TICK: begin
            ms_in = tick_ms;
            ok_in = 1'b1;
            wr_entry.stamp = tick_ms;
            if (pulse_act_ff && (tick_el >= {16'd0, pulse_len_ff})) begin
               pulse_act_in                = 1'b0;
               pins_in[bpc_pkg::PIN_RESET] = 1'b0;
               log_req           = 1'b1;
               wr_entry.kind     = bpc_pkg::EV_PULSE_END;
               wr_entry.origin   = pulse_org_ff;
               wr_entry.level    = 1'b0;
               wr_entry.argument = pulse_len_ff;
            end
         end
         bpc_pkg::OP_RELAY: begin
            pins_in[bpc_pkg::PIN_RELAY] = req_level;
            log_req = 1'b1;
            ok_in   = 1'b1;
         end
         bpc_pkg::OP_POWER: begin
            pins_in[bpc_pkg::PIN_POWER] = req_level;
            wr_entry.kind = bpc_pkg::EV_POWER;
            log_req = 1'b1;
            ok_in   = 1'b1;
         end
         bpc_pkg::OP_RESET: begin
            // direct level cancels any running pulse
            pulse_act_in                = 1'b0;
            pins_in[bpc_pkg::PIN_RESET] = req_level;
            wr_entry.kind = req_level ? bpc_pkg::EV_RST_ASSRT : bpc_pkg::EV_RST_REL;
            log_req = 1'b1;
            ok_in   = 1'b1;
         end
         bpc_pkg::OP_PULSE: begin
            if (req_pulse_length >= bpc_pkg::MIN_PULSE_LEN &&
                req_pulse_length <= max_pulse_ff && !pulse_act_ff) begin
               pulse_act_in                = 1'b1;
               pulse_start_in              = ms_ff;
               pulse_len_in                = req_pulse_length;
               pulse_org_in                = req_origin_id;
               pins_in[bpc_pkg::PIN_RESET] = 1'b1;
               ok_in                       = 1'b1;
            end
         end
         bpc_pkg::OP_LOADER: begin
            pins_in[bpc_pkg::PIN_LOADER] = req_level;
            wr_entry.kind = bpc_pkg::EV_LOADER;
            log_req = 1'b1;
            ok_in   = 1'b1;
         end
         bpc_pkg::OP_MASKROM: begin
            pins_in[bpc_pkg::PIN_MASKROM] = req_level;
            wr_entry.kind = bpc_pkg::EV_MASKROM;
            log_req = 1'b1;
            ok_in   = 1'b1;
         end
         bpc_pkg::OP_BUTTON: begin
            // first press always passes, later ones are debounced
            if (req_button_pressed &&
                (!press_seen_ff || (press_el >= {16'd0, debounce_ff}))) begin
               press_seen_in = 1'b1;
               last_press_in = ms_ff;
               pins_in[bpc_pkg::PIN_RELAY] = !pins_ff[bpc_pkg::PIN_RELAY];
               wr_entry.origin = 1'b1;
               wr_entry.level  = !pins_ff[bpc_pkg::PIN_RELAY];
               log_req = 1'b1;
               ok_in   = 1'b1;
            end
         end
         bpc_pkg::OP_POP: begin
            if (!ring_empty) begin
               pop_take    = 1'b1;
               ev_valid_in = 1'b1;
               ok_in       = 1'b1;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase

      wr_en   = take && log_req && !ring_full;
      head_in = wr_en ? head_nxt : head_ff;
      tail_in = (take && pop_take) ? tail_nxt : tail_ff;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= bpc_pkg::DEBOUNCE_RESET;
         max_pulse_ff <= bpc_pkg::MAX_PULSE_RESET;
      end else if (csr_we) begin
         unique case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wdata;
            bpc_pkg::CSR_MAX_PULSE: max_pulse_ff <= csr_wdata;
            default:                debounce_ff  <= debounce_ff;
         endcase
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff        <= '0;
         ms_ff          <= '0;
         pulse_act_ff   <= 1'b0;
         pulse_start_ff <= '0;
         pulse_len_ff   <= '0;
         pulse_org_ff   <= 1'b0;
         last_press_ff  <= '0;
         press_seen_ff  <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         ok_ff          <= 1'b0;
         ev_valid_ff    <= 1'b0;
      end else begin
         if (take) begin
            pins_ff        <= pins_in;
            ms_ff          <= ms_in;
            pulse_act_ff   <= pulse_act_in;
            pulse_start_ff <= pulse_start_in;
            pulse_len_ff   <= pulse_len_in;
            pulse_org_ff   <= pulse_org_in;
            last_press_ff  <= last_press_in;
            press_seen_ff  <= press_seen_in;
            head_ff        <= head_in;
            tail_ff        <= tail_in;
            ok_ff          <= ok_in;
            ev_valid_ff    <= ev_valid_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Event ring memory, registered read on pop
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[head_ff] <= wr_entry;
      end
      if (take && pop_take) begin
         rd_data_ff <= ring_mem[tail_ff];
      end
   end

   // Pulse time left, from state after the item now shown
   assign el_now    = ms_ff - pulse_start_ff;
   assign left_full = {16'd0, pulse_len_ff} - el_now;

   // Only one result is outstanding, so state registers match it
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command_ok     = ok_ff;
   assign rsp_pin_states     = pins_ff;
   assign rsp_pulse_running  = pulse_act_ff;
   assign rsp_pulse_left     = (pulse_act_ff && (el_now < {16'd0, pulse_len_ff}))
                               ? left_full[15:0] : 16'd0;
   assign rsp_event_valid    = ev_valid_ff;
   assign rsp_event_kind     = ev_valid_ff ? rd_data_ff.kind     : 3'd0;
   assign rsp_event_origin   = ev_valid_ff ? rd_data_ff.origin   : 1'b0;
   assign rsp_event_level    = ev_valid_ff ? rd_data_ff.level    : 1'b0;
   assign rsp_event_argument = ev_valid_ff ? rd_data_ff.argument : 16'd0;
   assign rsp_event_time     = ev_valid_ff ? rd_data_ff.stamp    : 32'd0;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the board pin controller core.
module tb;

   // One request item, one result item, one row of the directed plan
   typedef struct packed {
      logic [3:0]  opcode;
      logic        level;
      logic [15:0] pulse_length;
      logic        origin_id;
      logic        button_pressed;
   } board_cmd_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  pins;
      logic        running;
      logic [15:0] left;
      logic        ev_valid;
      logic [2:0]  kind;
      logic        origin;
      logic        level;
      logic [15:0] argument;
      logic [31:0] stamp;
   } pin_status_type;

   typedef struct packed {
      board_cmd_type cmd;
      logic          typed;
      logic          ok;
      logic [4:0]    pins;
   } plan_row_type;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PLAN_ROWS    = 25;
   localparam int RANDOM_ITEMS = 135;
   localparam int NUM_PHASES   = 4;

   // Directed plan, run with the reset settings (debounce 80, max pulse 5000).
   // The last seven rows pop the ring that the rows before filled up.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b0, 5'h00}, // pop, empty ring
      '{'{bpc_pkg::OP_TICK, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 5'h00},
      '{'{bpc_pkg::OP_RELAY, 1'b1, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 5'h01},
      '{'{bpc_pkg::OP_POWER, 1'b1, 16'd0, 1'b1, 1'b0}, 1'b1, 1'b1, 5'h03},
      '{'{bpc_pkg::OP_LOADER, 1'b1, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 5'h0B},
      '{'{bpc_pkg::OP_MASKROM, 1'b1, 16'd0, 1'b1, 1'b0}, 1'b1, 1'b1, 5'h1B},
      '{'{bpc_pkg::OP_PULSE, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b0, 5'h1B}, // zero length
      '{'{bpc_pkg::OP_PULSE, 1'b0, 16'd5001, 1'b0, 1'b0}, 1'b1, 1'b0, 5'h1B}, // over max
      '{'{bpc_pkg::OP_PULSE, 1'b0, 16'd5000, 1'b0, 1'b0}, 1'b1, 1'b1, 5'h1F}, // exactly max
      '{'{bpc_pkg::OP_PULSE, 1'b0, 16'd2, 1'b0, 1'b0}, 1'b1, 1'b0, 5'h1F}, // already running
      '{'{bpc_pkg::OP_RESET, 1'b0, 16'd0, 1'b1, 1'b0}, 1'b1, 1'b1, 5'h1B}, // cancels pulse
      '{'{bpc_pkg::OP_PULSE, 1'b0, 16'd1, 1'b1, 1'b0}, 1'b1, 1'b1, 5'h1F},
      '{'{bpc_pkg::OP_TICK, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00}, // pulse ends
      '{'{bpc_pkg::OP_BUTTON, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b0, 5'h1B}, // release edge
      '{'{bpc_pkg::OP_BUTTON, 1'b0, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b1, 5'h1A}, // first press
      '{'{bpc_pkg::OP_BUTTON, 1'b0, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 5'h1A}, // bounce
      '{'{bpc_pkg::OP_RESET, 1'b1, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 5'h1E}, // ring full
      '{'{4'd15, 1'b1, 16'hFFFF, 1'b1, 1'b1}, 1'b1, 1'b0, 5'h1E}, // unknown op
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00},
      '{'{bpc_pkg::OP_POP, 1'b0, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 5'h00}
   };

   // Register settings and idling per random phase
   localparam logic [15:0] PH_DEBOUNCE  [NUM_PHASES] = '{16'd0, 16'd65535, 16'd5, 16'd30};
   localparam logic [15:0] PH_MAX_PULSE [NUM_PHASES] = '{16'd1, 16'd65535, 16'd20, 16'd8};
   localparam int          PH_SEND_IDLE [NUM_PHASES] = '{21, 71, 0, 0};
   localparam int          PH_RECV_IDLE [NUM_PHASES] = '{71, 21, 0, 0};

   localparam bpc_pkg::opcode_type PIN_OPS [4] = '{bpc_pkg::OP_RELAY, bpc_pkg::OP_POWER,
                                                   bpc_pkg::OP_LOADER, bpc_pkg::OP_MASKROM};

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_opcode;
   logic        req_level;
   logic [15:0] req_pulse_length;
   logic        req_origin_id;
   logic        req_button_pressed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_command_ok;
   logic [4:0]  rsp_pin_states;
   logic        rsp_pulse_running;
   logic [15:0] rsp_pulse_left;
   logic        rsp_event_valid;
   logic [2:0]  rsp_event_kind;
   logic        rsp_event_origin;
   logic        rsp_event_level;
   logic [15:0] rsp_event_argument;
   logic [31:0] rsp_event_time;

   board_pin_control_with_reset_pulse_core dut (.*);

   // Predicted board state and register copies
   logic [15:0]        debounce_cfg;
   logic [15:0]        max_pulse_cfg;
   logic [4:0]         pins;
   logic [31:0]        ms_now;
   logic               pulse_on;
   logic [31:0]        pulse_t0;
   logic [15:0]        pulse_len;
   logic               pulse_org;
   logic [31:0]        last_press;
   logic               press_any;
   bpc_pkg::event_type event_log [$];

   pin_status_type expected_status [$];
   int             send_idle;
   int             recv_idle;
   int             mismatch_count;
   int             items_sent;
   int             results_checked;
   int             pulse_ends;
   int             presses_taken;
   int             events_popped;
   int             cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_status.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Ring keeps at most depth-1 events; newer ones are dropped when full
   function automatic void log_event(bpc_pkg::event_kind_type k, logic o, logic l,
                                     logic [15:0] a);
      if (event_log.size() < bpc_pkg::RING_DEPTH_DEF - 1)
         event_log.push_back('{kind: k, origin: o, level: l, argument: a, stamp: ms_now});
   endfunction

   // Advance the predicted board by one item and work out its result
   task automatic predict_pin_status(input board_cmd_type c, output pin_status_type r);
      logic [31:0]        elapsed;
      logic               relay_next;
      bpc_pkg::event_type ev;
      r = '0;
      case (c.opcode)
         bpc_pkg::OP_TICK: begin
            ms_now  = ms_now + 32'd1;
            elapsed = ms_now - pulse_t0;
            if (pulse_on && elapsed >= {16'd0, pulse_len}) begin
               pulse_on                 = 1'b0;
               pins[bpc_pkg::PIN_RESET] = 1'b0;
               log_event(bpc_pkg::EV_PULSE_END, pulse_org, 1'b0, pulse_len);
               pulse_ends++;
            end
            r.ok = 1'b1;
         end
         bpc_pkg::OP_RELAY: begin
            pins[bpc_pkg::PIN_RELAY] = c.level;
            log_event(bpc_pkg::EV_RELAY, c.origin_id, c.level, 16'd0);
            r.ok = 1'b1;
         end
         bpc_pkg::OP_POWER: begin
            pins[bpc_pkg::PIN_POWER] = c.level;
            log_event(bpc_pkg::EV_POWER, c.origin_id, c.level, 16'd0);
            r.ok = 1'b1;
         end
         bpc_pkg::OP_RESET: begin
            // a direct level write kills any running pulse
            pulse_on                 = 1'b0;
            pins[bpc_pkg::PIN_RESET] = c.level;
            log_event(c.level ? bpc_pkg::EV_RST_ASSRT : bpc_pkg::EV_RST_REL, c.origin_id,
                      c.level, 16'd0);
            r.ok = 1'b1;
         end
         bpc_pkg::OP_PULSE: begin
            if (c.pulse_length >= bpc_pkg::MIN_PULSE_LEN && c.pulse_length <= max_pulse_cfg &&
                !pulse_on) begin
               pulse_on                 = 1'b1;
               pulse_t0                 = ms_now;
               pulse_len                = c.pulse_length;
               pulse_org                = c.origin_id;
               pins[bpc_pkg::PIN_RESET] = 1'b1;
               r.ok                     = 1'b1;
            end
         end
         bpc_pkg::OP_LOADER: begin
            pins[bpc_pkg::PIN_LOADER] = c.level;
            log_event(bpc_pkg::EV_LOADER, c.origin_id, c.level, 16'd0);
            r.ok = 1'b1;
         end
         bpc_pkg::OP_MASKROM: begin
            pins[bpc_pkg::PIN_MASKROM] = c.level;
            log_event(bpc_pkg::EV_MASKROM, c.origin_id, c.level, 16'd0);
            r.ok = 1'b1;
         end
         bpc_pkg::OP_BUTTON: begin
            // first press always counts, later ones need debounce_cfg ms of quiet
            elapsed = ms_now - last_press;
            if (c.button_pressed && (!press_any || elapsed >= {16'd0, debounce_cfg})) begin
               relay_next               = ~pins[bpc_pkg::PIN_RELAY];
               press_any                = 1'b1;
               last_press               = ms_now;
               pins[bpc_pkg::PIN_RELAY] = relay_next;
               log_event(bpc_pkg::EV_RELAY, 1'b1, relay_next, 16'd0);
               presses_taken++;
               r.ok = 1'b1;
            end
         end
         bpc_pkg::OP_POP: begin
            if (event_log.size() != 0) begin
               ev         = event_log.pop_front();
               r.ok       = 1'b1;
               r.ev_valid = 1'b1;
               r.kind     = ev.kind;
               r.origin   = ev.origin;
               r.level    = ev.level;
               r.argument = ev.argument;
               r.stamp    = ev.stamp;
               events_popped++;
            end
         end
         default: ;
      endcase
      r.pins    = pins;
      r.running = pulse_on;
      if (pulse_on) begin
         elapsed = ms_now - pulse_t0;
         r.left  = (elapsed >= {16'd0, pulse_len}) ? 16'd0 : pulse_len - elapsed[15:0];
      end
   endtask

   // Present one item, hold it until taken, then queue its expected result
   task automatic send_cmd(input board_cmd_type c, input logic typed, input logic t_ok,
                           input logic [4:0] t_pins);
      pin_status_type r;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= c.opcode;
      req_level          <= c.level;
      req_pulse_length   <= c.pulse_length;
      req_origin_id      <= c.origin_id;
      req_button_pressed <= c.button_pressed;
      do @(posedge clock); while (!req_ready);
      predict_pin_status(c, r);
      if (typed) begin
         r.ok   = t_ok;
         r.pins = t_pins;
      end
      expected_status.push_back(r);
      items_sent++;
   endtask

   // Mostly ticks and pin writes, short pulses, presses and frequent pops
   function automatic board_cmd_type random_cmd();
      board_cmd_type c;
      int            pick;
      pick             = $urandom_range(0, 99);
      c.level          = 1'($urandom_range(0, 1));
      c.origin_id      = 1'($urandom_range(0, 1));
      c.button_pressed = ($urandom_range(0, 9) != 0);
      c.pulse_length   = 16'($urandom_range(0, 65535));
      if (pick < 34)      c.opcode = bpc_pkg::OP_TICK;
      else if (pick < 54) c.opcode = PIN_OPS[$urandom_range(0, 3)];
      else if (pick < 57) c.opcode = bpc_pkg::OP_RESET;
      else if (pick < 68) c.opcode = bpc_pkg::OP_PULSE;
      else if (pick < 80) c.opcode = bpc_pkg::OP_BUTTON;
      else if (pick < 97) c.opcode = bpc_pkg::OP_POP;
      else                c.opcode = 4'($urandom_range(9, 15));
      if (c.opcode == bpc_pkg::OP_PULSE) begin
         case ($urandom_range(0, 9))
            0:       c.pulse_length = 16'd0;
            1:       c.pulse_length = 16'($urandom_range(0, 65535));
            2:       c.pulse_length = max_pulse_cfg;
            3:       c.pulse_length = max_pulse_cfg + 16'd1;
            default: c.pulse_length = 16'($urandom_range(1, 6));
         endcase
      end
      return c;
   endfunction

   task automatic write_csr(input bpc_pkg::csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == bpc_pkg::CSR_DEBOUNCE) debounce_cfg = value;
      else                              max_pulse_cfg = value;
   endtask

   // Let every queued result come back before touching registers or ending
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic string show(pin_status_type s);
      return {$sformatf("ok=%0b pins=%05b run=%0b left=%0d ev=%0b ", s.ok, s.pins,
                        s.running, s.left, s.ev_valid),
              $sformatf("kind=%0d org=%0b lvl=%0b arg=%0d t=%0d", s.kind, s.origin,
                        s.level, s.argument, s.stamp)};
   endfunction

   // Result side: random back pressure and compare against the oldest prediction
   always @(posedge clock) begin
      pin_status_type got;
      pin_status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_command_ok, rsp_pin_states, rsp_pulse_running, rsp_pulse_left,
                    rsp_event_valid, rsp_event_kind, rsp_event_origin, rsp_event_level,
                    rsp_event_argument, rsp_event_time};
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result at cycle %0d: %s", cycles, show(got));
            end else begin
               want = expected_status.pop_front();
               results_checked++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at cycle %0d\n  exp %s\n  got %s", cycles,
                              show(want), show(got));
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   initial begin
      int i;
      int p;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= bpc_pkg::CSR_DEBOUNCE;
      csr_wdata          <= 16'd0;
      req_valid          <= 1'b0;
      req_opcode         <= bpc_pkg::OP_TICK;
      req_level          <= 1'b0;
      req_pulse_length   <= 16'd0;
      req_origin_id      <= 1'b0;
      req_button_pressed <= 1'b0;
      debounce_cfg    = bpc_pkg::DEBOUNCE_RESET;
      max_pulse_cfg   = bpc_pkg::MAX_PULSE_RESET;
      pins            = '0;
      ms_now          = '0;
      pulse_on        = 1'b0;
      pulse_t0        = '0;
      pulse_len       = '0;
      pulse_org       = 1'b0;
      last_press      = '0;
      press_any       = 1'b0;
      mismatch_count  = 0;
      items_sent      = 0;
      results_checked = 0;
      pulse_ends      = 0;
      presses_taken   = 0;
      events_popped   = 0;
      send_idle       = PH_SEND_IDLE[0];
      recv_idle       = PH_RECV_IDLE[0];

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed plan under reset settings
      for (i = 0; i < PLAN_ROWS; i++)
         send_cmd(PLAN[i].cmd, PLAN[i].typed, PLAN[i].ok, PLAN[i].pins);
      settle();

      // Random phases, each with its own register setting and idling mix
      for (p = 0; p < NUM_PHASES; p++) begin
         write_csr(bpc_pkg::CSR_DEBOUNCE, PH_DEBOUNCE[p]);
         write_csr(bpc_pkg::CSR_MAX_PULSE, PH_MAX_PULSE[p]);
         send_idle = PH_SEND_IDLE[p];
         recv_idle = PH_RECV_IDLE[p];
         for (i = 0; i < RANDOM_ITEMS; i++)
            send_cmd(random_cmd(), 1'b0, 1'b0, 5'h00);
         settle();
      end

      $display("%0d items over %0d register settings, %0d results checked, %0d mismatches",
               items_sent, NUM_PHASES + 1, results_checked, mismatch_count);
      $display("%0d pulse ends, %0d button presses taken, %0d events read back",
               pulse_ends, presses_taken, events_popped);
      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
src/bpc_pkg.sv
src/board_pin_control_with_reset_pulse_core.sv
verif/tb.sv
